/* src/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and codes for the minimum tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int OCC_W = 9;

  typedef logic signed [31:0] word_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2
  } fault_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

/* src/mts_if.sv */
// ----------------------------------------------------------------------------
// mts_req_if / mts_rsp_if
// valid/ready channels for stack requests and results
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] push_value;

  modport source (output valid, cmd, push_value, input ready);
  modport sink (input valid, cmd, push_value, output ready);
endinterface

interface mts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic [8:0]         occupancy;
  logic               is_empty;
  logic [1:0]         fault;

  modport source (output valid, top_value, min_value, occupancy, is_empty, fault,
                  input ready);
  modport sink (input valid, top_value, min_value, occupancy, is_empty, fault,
                output ready);
endinterface

/* src/mts_cell.sv */
// ----------------------------------------------------------------------------
// mts_cell
// one stack entry; loads from the upper neighbor on push, lower on pop
// ----------------------------------------------------------------------------
module mts_cell (
  input  logic            clk,
  input  mts_pkg::shift_t ctl,
  input  mts_pkg::word_t  upper,
  input  mts_pkg::word_t  lower,
  output mts_pkg::word_t  data
);
  import mts_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= upper;
    end else if (ctl.pop) begin
      data <= lower;
    end
  end

endmodule

/* src/mts_chain.sv */
// ----------------------------------------------------------------------------
// mts_chain
// row of cells forming a shift stack; cell 0 is the top
// ----------------------------------------------------------------------------
module mts_chain #(
  parameter int DEPTH = 256
) (
  input  logic            clk,
  input  mts_pkg::shift_t ctl,
  input  mts_pkg::word_t  push_data,
  output mts_pkg::word_t  head0,
  output mts_pkg::word_t  head1
);
  import mts_pkg::*;

  word_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t upper;
    word_t lower;

    if (i == 0) begin : g_first
      assign upper = push_data;
    end else begin : g_mid
      assign upper = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign lower = cells[i];
    end else begin : g_inner
      assign lower = cells[i+1];
    end

    mts_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .upper (upper),
      .lower (lower),
      .data  (cells[i])
    );
  end

  assign head0 = cells[0];
  assign head1 = cells[1];

endmodule

/* src/min_tracking_stack.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack
// lifo of signed 32-bit values that reports its running minimum
// ----------------------------------------------------------------------------
// Each request (push or pop) is accepted and its result appears in the
// output register on the next cycle; a new request is accepted every cycle as
// long as the result side keeps up. Values sit in a shift chain of DEPTH
// cells and the minima in a second chain of the same length, so the top two
// entries of each are always at hand and no memory port limits the rate. A
// pop on an empty stack reports an underflow fault, a push on a full stack an
// overflow fault; neither changes the stack. Top and minimum read 0 when
// empty.
module min_tracking_stack #(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  mts_req_if.sink   req,
  mts_rsp_if.source rsp
);
  import mts_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] min_count;
  logic [CW-1:0] min_count_next;

  shift_t v_ctl;
  shift_t m_ctl;
  word_t  v_head0, v_head1;
  word_t  m_head0, m_head1;

  logic   accept;
  logic   is_push;
  logic   full;
  logic   empty;
  word_t  top_sel;
  word_t  min_sel;
  fault_t fault_next;

  mts_chain #(.DEPTH(DEPTH)) u_values (
    .clk       (clk),
    .ctl       (v_ctl),
    .push_data (req.push_value),
    .head0     (v_head0),
    .head1     (v_head1)
  );

  mts_chain #(.DEPTH(DEPTH)) u_minima (
    .clk       (clk),
    .ctl       (m_ctl),
    .push_data (req.push_value),
    .head0     (m_head0),
    .head1     (m_head1)
  );

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_push   = (req.cmd == CMD_PUSH);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    v_ctl.push = accept && is_push && !full;
    v_ctl.pop  = accept && !is_push && !empty;
    m_ctl.push = v_ctl.push && ((min_count == '0) || (req.push_value <= m_head0));
    m_ctl.pop  = v_ctl.pop && (min_count != '0) && (v_head0 == m_head0);
  end

  always_comb begin
    count_next     = count;
    min_count_next = min_count;
    if (v_ctl.push) begin
      count_next = count + CW'(1);
    end else if (v_ctl.pop) begin
      count_next = count - CW'(1);
    end
    if (m_ctl.push) begin
      min_count_next = min_count + CW'(1);
    end else if (m_ctl.pop) begin
      min_count_next = min_count - CW'(1);
    end
  end

  always_comb begin
    fault_next = FAULT_NONE;
    if (accept && is_push && full) begin
      fault_next = FAULT_OVERFLOW;
    end else if (accept && !is_push && empty) begin
      fault_next = FAULT_UNDERFLOW;
    end
    if (v_ctl.push) begin
      top_sel = req.push_value;
    end else if (v_ctl.pop) begin
      top_sel = v_head1;
    end else begin
      top_sel = v_head0;
    end
    if (m_ctl.push) begin
      min_sel = req.push_value;
    end else if (m_ctl.pop) begin
      min_sel = m_head1;
    end else begin
      min_sel = m_head0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      min_count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count     <= count_next;
      min_count <= min_count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.top_value <= (count_next == '0) ? '0 : top_sel;
      rsp.min_value <= (min_count_next == '0) ? '0 : min_sel;
      rsp.occupancy <= OCC_W'(count_next);
      rsp.is_empty  <= (count_next == '0);
      rsp.fault     <= fault_next;
    end
  end

  // checks
  a_min_le_count: assert property (@(posedge clk) disable iff (rst)
    min_count <= count)
    else $error("minimum chain deeper than value chain");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    v_ctl.push |=> rsp.valid && rsp.top_value == $past(req.push_value)
                   && rsp.fault == FAULT_NONE)
    else $error("pushed value not on top");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    accept && !is_push && empty |=> rsp.fault == FAULT_UNDERFLOW && rsp.is_empty
                                    && count == '0)
    else $error("pop on empty not flagged");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    accept && is_push && full |=> rsp.fault == FAULT_OVERFLOW && $stable(count))
    else $error("push on full not flagged");

endmodule
